// File: sv/sbc_pkg.sv
// shared types, s-box tables and round functions for the serpent block cipher
package sbc_pkg;

   typedef logic [3:0][31:0] blk_type;

   localparam logic [31:0] GOLDEN = 32'h9E37_79B9;

   localparam logic [2:0] CSR_KEY_WORD0    = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD1    = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD2    = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD3    = 3'd3;
   localparam logic [2:0] CSR_KEY_BYTES    = 3'd4;
   localparam logic [2:0] CSR_ROUND_GROUPS = 3'd5;

   localparam logic [63:0] SBOX_FWD [8] = '{
      64'h38F1A65BED42709C, 64'hFC27905A1BE86D34,
      64'h86793CAFD1E40B52, 64'h0FB8C963D124A75E,
      64'h1F83C0B6254A9E7D, 64'hF52B4A9C03E8D671,
      64'h72C5846BE91FD3A0, 64'h1DF0E82B74CA9356
   };
   localparam logic [63:0] SBOX_INV [8] = '{
      64'hD3B0A65C1E47F982, 64'h582EF6C3B4791DA0,
      64'hC9F4BE12036D58A7, 64'h09A7BE6D35C248F1,
      64'h5083A97E2CB64FD1, 64'h8F2941DEB6537CA0,
      64'hFA1D536049E72C8B, 64'h306D9EF85CB7A142
   };

   typedef struct packed {
      logic       load_block;
      logic       win_init;
      logic       exp_step;
      logic       keys_done;
      logic       rd_en;
      logic       round;
      logic       first;
      logic       last;
      logic       lin_en;
      logic       dec;
      logic [2:0] sbox_sel;
   } cmd_type;

   typedef struct packed {
      logic keys_ready;
   } status_type;

   // bitsliced s-box: nibble n counts from the top of the table word
   function automatic blk_type sbox_apply(input logic [63:0] tab, input blk_type w);
      blk_type    o;
      logic [3:0] n;
      logic [3:0] y;
      for (int j = 0; j < 32; j++) begin
         n = {w[3][j], w[2][j], w[1][j], w[0][j]};
         y = tab[(6'd60 - {n, 2'b00}) +: 4];
         for (int q = 0; q < 4; q++) begin
            o[q][j] = y[q];
         end
      end
      return o;
   endfunction

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic blk_type lin(input blk_type xi);
      blk_type x;
      x = xi;
      x[0] = rol(x[0], 13);
      x[2] = rol(x[2], 3);
      x[1] = x[1] ^ x[0] ^ x[2];
      x[3] = x[3] ^ x[2] ^ (x[0] << 3);
      x[1] = rol(x[1], 1);
      x[3] = rol(x[3], 7);
      x[0] = x[0] ^ x[1] ^ x[3];
      x[2] = x[2] ^ x[3] ^ (x[1] << 7);
      x[0] = rol(x[0], 5);
      x[2] = rol(x[2], 22);
      return x;
   endfunction

   function automatic blk_type lin_inv(input blk_type xi);
      blk_type x;
      x = xi;
      x[2] = rol(x[2], 10);
      x[0] = rol(x[0], 27);
      x[2] = x[2] ^ x[3] ^ (x[1] << 7);
      x[0] = x[0] ^ x[1] ^ x[3];
      x[3] = rol(x[3], 25);
      x[1] = rol(x[1], 31);
      x[3] = x[3] ^ x[2] ^ (x[0] << 3);
      x[1] = x[1] ^ x[0] ^ x[2];
      x[2] = rol(x[2], 29);
      x[0] = rol(x[0], 19);
      return x;
   endfunction

endpackage

// File: sv/sbc_datapath.sv
// serpent datapath: config registers, key schedule window, subkey memory, round unit
module sbc_datapath #(
   parameter int MAX_ROUND_GROUPS = 4,
   parameter int CW = $clog2(8 * MAX_ROUND_GROUPS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_write_data,
   input  logic [63:0]         req_data_in_low,
   input  logic [63:0]         req_data_in_high,
   input  sbc_pkg::cmd_type    cmd,
   input  logic [CW-1:0]       rd_addr,
   input  logic [CW-1:0]       wr_addr,
   output sbc_pkg::status_type status,
   output logic [CW-1:0]       rounds,
   output logic [63:0]         rsp_data_out_low,
   output logic [63:0]         rsp_data_out_high
);
   localparam int DEPTH = 8 * MAX_ROUND_GROUPS + 1;
   localparam int GW = $clog2(MAX_ROUND_GROUPS + 1);

   logic [3:0][63:0] key_ff;
   logic [5:0]       key_bytes_ff;
   logic [2:0]       groups_ff;
   logic             ready_ff;
   sbc_pkg::blk_type x_ff, x_in;
   logic [7:0][31:0] win_ff, win_in;
   logic [127:0]     mem [DEPTH];
   logic [127:0]     key_rd_ff;
   logic [GW-1:0]    groups_clamp;
   logic [5:0]       len;
   logic [7:0][31:0] pre;
   logic [3:0][31:0] nw;
   logic [31:0]      idx;
   sbc_pkg::blk_type row;
   sbc_pkg::blk_type key, t, s, y;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         key_bytes_ff <= 6'd32;
         groups_ff    <= 3'd4;
         ready_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               sbc_pkg::CSR_KEY_WORD0:    key_ff[0] <= csr_write_data;
               sbc_pkg::CSR_KEY_WORD1:    key_ff[1] <= csr_write_data;
               sbc_pkg::CSR_KEY_WORD2:    key_ff[2] <= csr_write_data;
               sbc_pkg::CSR_KEY_WORD3:    key_ff[3] <= csr_write_data;
               sbc_pkg::CSR_KEY_BYTES:    key_bytes_ff <= csr_write_data[5:0];
               sbc_pkg::CSR_ROUND_GROUPS: groups_ff <= csr_write_data[2:0];
               default: ;
            endcase
            if (csr_index <= sbc_pkg::CSR_ROUND_GROUPS) begin
               ready_ff <= 1'b0;
            end
         end else if (cmd.keys_done) begin
            ready_ff <= 1'b1;
         end
      end
   end

   assign status.keys_ready = ready_ff;

   always_comb begin
      if (groups_ff == 3'd0) begin
         groups_clamp = GW'(1);
      end else if (int'(groups_ff) > MAX_ROUND_GROUPS) begin
         groups_clamp = GW'(MAX_ROUND_GROUPS);
      end else begin
         groups_clamp = GW'(groups_ff);
      end
   end
   assign rounds = CW'({groups_clamp, 3'b000});

   // key bytes past the length are dropped, short keys get a single pad bit
   always_comb begin
      len = (key_bytes_ff > 6'd32) ? 6'd32 : key_bytes_ff;
      pre = key_ff;
      for (int j = 0; j < 32; j++) begin
         if (6'(j) >= len) begin
            pre[j / 4][(j % 4) * 8 +: 8] = 8'h00;
         end
      end
      if (len < 6'd32) begin
         pre[len[4:2]][{len[1:0], 3'b000}] = 1'b1;
      end
   end

   // four dependent recurrence steps per row
   always_comb begin
      idx   = {{(30 - CW){1'b0}}, wr_addr, 2'b00};
      nw[0] = sbc_pkg::rol(sbc_pkg::GOLDEN ^ idx ^ win_ff[0] ^ win_ff[3] ^ win_ff[5]
                           ^ win_ff[7], 11);
      nw[1] = sbc_pkg::rol(sbc_pkg::GOLDEN ^ (idx | 32'd1) ^ win_ff[1] ^ win_ff[4]
                           ^ win_ff[6] ^ nw[0], 11);
      nw[2] = sbc_pkg::rol(sbc_pkg::GOLDEN ^ (idx | 32'd2) ^ win_ff[2] ^ win_ff[5]
                           ^ win_ff[7] ^ nw[1], 11);
      nw[3] = sbc_pkg::rol(sbc_pkg::GOLDEN ^ (idx | 32'd3) ^ win_ff[3] ^ win_ff[6]
                           ^ nw[0] ^ nw[2], 11);
      row   = sbc_pkg::sbox_apply(sbc_pkg::SBOX_FWD[3'd3 - wr_addr[2:0]], nw);
      win_in = win_ff;
      if (cmd.win_init) begin
         win_in = pre;
      end else if (cmd.exp_step) begin
         win_in = {nw, win_ff[7:4]};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (cmd.exp_step) begin
         mem[wr_addr] <= row;
      end
      if (cmd.rd_en) begin
         key_rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      key  = key_rd_ff;
      t    = x_ff ^ key;
      s    = sbc_pkg::sbox_apply(sbc_pkg::SBOX_FWD[cmd.sbox_sel], t);
      y    = cmd.lin_en ? sbc_pkg::lin_inv(x_ff) : x_ff;
      x_in = x_ff;
      if (cmd.load_block) begin
         x_in = {req_data_in_high, req_data_in_low};
      end else if (cmd.round) begin
         if (!cmd.dec) begin
            if (cmd.last) begin
               x_in = t;
            end else begin
               x_in = cmd.lin_en ? sbc_pkg::lin(s) : s;
            end
         end else if (cmd.first) begin
            x_in = t;
         end else begin
            x_in = sbc_pkg::sbox_apply(sbc_pkg::SBOX_INV[cmd.sbox_sel], y) ^ key;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   assign rsp_data_out_low  = x_ff[1:0];
   assign rsp_data_out_high = x_ff[3:2];

endmodule

// File: sv/sbc_ctrl.sv
// serpent controller: key expansion sequencing and round counting
module sbc_ctrl #(
   parameter int MAX_ROUND_GROUPS = 4,
   parameter int CW = $clog2(8 * MAX_ROUND_GROUPS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_action,
   input  sbc_pkg::status_type status,
   input  logic [CW-1:0]       rounds,
   output sbc_pkg::cmd_type    cmd,
   output logic [CW-1:0]       rd_addr,
   output logic [CW-1:0]       wr_addr,
   output logic                busy,
   output logic                rsp_strobe
);
   typedef enum logic [2:0] {
      S_IDLE, S_EXP_INIT, S_EXPAND, S_FETCH, S_ROUND
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] cnt_ff;
   logic          dec_ff;
   logic          done_ff;
   logic [CW-1:0] rnd;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = done_ff;
   assign wr_addr    = cnt_ff;
   assign rnd        = dec_ff ? (rounds - cnt_ff) : cnt_ff;

   always_comb begin
      cmd          = '0;
      cmd.dec      = dec_ff;
      cmd.sbox_sel = rnd[2:0];
      rd_addr      = dec_ff ? (rnd - CW'(1)) : (cnt_ff + CW'(1));
      case (state_ff)
         S_IDLE:     cmd.load_block = start;
         S_EXP_INIT: cmd.win_init = 1'b1;
         S_EXPAND: begin
            cmd.exp_step  = 1'b1;
            cmd.keys_done = (cnt_ff == rounds);
         end
         S_FETCH: begin
            cmd.rd_en = 1'b1;
            rd_addr   = dec_ff ? rounds : '0;
         end
         S_ROUND: begin
            cmd.round  = 1'b1;
            // no subkey is needed after the final round
            cmd.rd_en  = (cnt_ff != rounds);
            cmd.first  = (cnt_ff == '0);
            cmd.last   = (cnt_ff == rounds);
            cmd.lin_en = dec_ff ? (cnt_ff > CW'(1)) : (cnt_ff < rounds - CW'(1));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         dec_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  dec_ff   <= req_action;
                  state_ff <= status.keys_ready ? S_FETCH : S_EXP_INIT;
               end
            end
            S_EXP_INIT: begin
               cnt_ff   <= '0;
               state_ff <= S_EXPAND;
            end
            S_EXPAND: begin
               if (cnt_ff == rounds) begin
                  state_ff <= S_FETCH;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_FETCH: begin
               cnt_ff   <= '0;
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               if (cnt_ff == rounds) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_strobe_after_round: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == S_ROUND))
      else $error("result strobe without a final round");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("result strobe longer than one cycle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");
   a_keys_before_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> (status.keys_ready || $past(state_ff == S_EXPAND)))
      else $error("rounds started without expanded subkeys");
`endif

endmodule

// File: sv/serpent_block_cipher.sv
// serpent block cipher top level
//
// usage:
//   csr_write_enable/csr_index/csr_write_data write key words 0..3, key byte
//   count and round groups; write only while busy is low. a write to any of
//   these registers marks the subkeys stale.
//   a transaction is accepted when start is high and busy is low; req_action
//   selects encrypt (0) or decrypt (1).
//   the result block appears on rsp_data_out_* for one cycle with rsp_strobe.
// operation:
//   R = 8 * round groups. an accepted transaction first reads a subkey from
//   memory, then runs one round per cycle through the round unit.
//   the first transaction after reset or a register write first runs key
//   expansion, one subkey row per cycle into the memory.
//   a new transaction may start in the strobe cycle; none is accepted while
//   busy is high.
// reset sets the control state and config registers to defaults; subkeys are
// rebuilt on the next transaction. the receiver cannot stall results.
module serpent_block_cipher #(
   parameter int MAX_ROUND_GROUPS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [63:0] req_data_in_low,
   input  logic [63:0] req_data_in_high,
   output logic        rsp_strobe,
   output logic [63:0] rsp_data_out_low,
   output logic [63:0] rsp_data_out_high,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   localparam int CW = $clog2(8 * MAX_ROUND_GROUPS + 1);

   sbc_pkg::cmd_type    cmd;
   sbc_pkg::status_type status;
   logic [CW-1:0]       rd_addr;
   logic [CW-1:0]       wr_addr;
   logic [CW-1:0]       rounds;

   sbc_ctrl #(.MAX_ROUND_GROUPS(MAX_ROUND_GROUPS), .CW(CW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .rounds     (rounds),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   sbc_datapath #(.MAX_ROUND_GROUPS(MAX_ROUND_GROUPS), .CW(CW)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_data_in_low   (req_data_in_low),
      .req_data_in_high  (req_data_in_high),
      .cmd               (cmd),
      .rd_addr           (rd_addr),
      .wr_addr           (wr_addr),
      .status            (status),
      .rounds            (rounds),
      .rsp_data_out_low  (rsp_data_out_low),
      .rsp_data_out_high (rsp_data_out_high)
   );

endmodule
